>>> rtl/calendar_date_difference_unit_macros.svh
// Assertion macros for the calendar date difference unit.
// Each macro samples on clk_i and is disabled while rst_ni is low.
`ifndef CALENDAR_DATE_DIFFERENCE_UNIT_MACROS_SVH
`define CALENDAR_DATE_DIFFERENCE_UNIT_MACROS_SVH

// Check a property at every clock edge outside reset.
`define CDD_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition in one cycle implies a consequence in the next.
`define CDD_ASSERT_NEXT(name, cond, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/cdd_pkg.sv
`default_nettype none

package cdd_pkg;

  // Borrow amounts for the time-of-day and month fields
  localparam logic signed [9:0] SecPerMin   = 10'sd60;
  localparam logic signed [9:0] MinPerHour  = 10'sd60;
  localparam logic signed [9:0] HourPerDay  = 10'sd24;
  localparam logic signed [9:0] MonPerYear  = 10'sd12;

  // Divisibility by 25 through the multiplicative inverse modulo 2^16
  localparam logic [15:0] InvTwentyFive = 16'd23593;
  localparam logic [15:0] Div25Max      = 16'd2621;

  // Month count and month lengths for a common year, index 0 is January
  localparam int unsigned NumMonths = 12;
  localparam logic [3:0]  February  = 4'd1;
  localparam logic [4:0]  LongMonth = 5'd31;
  localparam logic [4:0]  LeapFeb   = 5'd29;
  localparam logic [4:0]  MonthLen [NumMonths] = '{
    5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
    5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };

  // Gregorian leap-year rule on an unsigned 16-bit year
  function automatic logic is_leap(input logic [15:0] year);
    logic [15:0] prod;
    logic        div4;
    logic        div16;
    logic        div25;
    prod  = year * InvTwentyFive;
    div4  = (year[1:0] == 2'd0);
    div16 = (year[3:0] == 4'd0);
    div25 = (prod <= Div25Max);
    return div4 && (!div25 || div16);
  endfunction

  // Length of the month before the given month; January and out-of-range
  // months look back to a 31-day month
  function automatic logic [4:0] prev_month_len(input logic [3:0] month, input logic leap);
    logic [3:0] prev;
    logic [4:0] len;
    prev = month - 4'd1;
    if ((month == 4'd0) || (month > 4'(NumMonths))) begin
      len = LongMonth;
    end else if ((prev == February) && leap) begin
      len = LeapFeb;
    end else begin
      len = MonthLen[prev];
    end
    return len;
  endfunction

endpackage

`default_nettype wire

>>> rtl/calendar_date_difference_unit.sv
`default_nettype none

`include "calendar_date_difference_unit_macros.svh"

// Calendar date difference unit. Give it two broken-down timestamps with
// start high; busy stays low, so a new pair may be issued in every cycle.
// Each result appears on the diff ports with done_o high for one cycle: the
// input register and then the result register lie between a start beat and
// its result, and the borrow chain between them (with a 16-bit multiply per
// year for the leap-year check) is combinational, which keeps the rate of one
// pair per cycle. The receiver cannot stall, so it must take every done_o
// beat as it comes. The result is signed: when the first timestamp is later
// than the second, every field comes out negated; the days field may stay
// negative.
module calendar_date_difference_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [15:0] from_year_i,
  input  wire logic [3:0]  from_month_i,
  input  wire logic [4:0]  from_day_i,
  input  wire logic [4:0]  from_hour_i,
  input  wire logic [5:0]  from_minute_i,
  input  wire logic [5:0]  from_second_i,
  input  wire logic [15:0] till_year_i,
  input  wire logic [3:0]  till_month_i,
  input  wire logic [4:0]  till_day_i,
  input  wire logic [4:0]  till_hour_i,
  input  wire logic [5:0]  till_minute_i,
  input  wire logic [5:0]  till_second_i,
  output logic             done_o,
  output logic signed [16:0] diff_years_o,
  output logic signed [4:0]  diff_months_o,
  output logic signed [6:0]  diff_days_o,
  output logic signed [5:0]  diff_hours_o,
  output logic signed [6:0]  diff_minutes_o,
  output logic signed [6:0]  diff_seconds_o
);
  import cdd_pkg::*;

  logic        valid_q;
  logic [15:0] fy_q, ty_q;
  logic [3:0]  fmo_q, tmo_q;
  logic [4:0]  fd_q, td_q;
  logic [4:0]  fh_q, th_q;
  logic [5:0]  fmi_q, tmi_q;
  logic [5:0]  fs_q, ts_q;

  logic        accept;
  logic        rev;
  logic [15:0] a_y, b_y;
  logic [3:0]  a_mo, b_mo;
  logic [4:0]  a_d, b_d, a_h, b_h;
  logic [5:0]  a_mi, b_mi, a_s, b_s;
  logic        b_leap;
  logic [4:0]  plen;

  logic signed [9:0]  sec_raw, sec_r, min_raw, min_r, hr_raw, hr_r;
  logic signed [9:0]  day_raw, day_r, mon_raw, mon_r;
  logic signed [17:0] yr_r;
  logic signed [9:0]  sec_v, min_v, hr_v, day_v, mon_v;
  logic signed [17:0] yr_v;

  logic               done_q;
  logic signed [16:0] diff_years_q, diff_years_d;
  logic signed [4:0]  diff_months_q, diff_months_d;
  logic signed [6:0]  diff_days_q, diff_days_d;
  logic signed [5:0]  diff_hours_q, diff_hours_d;
  logic signed [6:0]  diff_minutes_q, diff_minutes_d;
  logic signed [6:0]  diff_seconds_q, diff_seconds_d;

  // Take a beat in every cycle
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Track whether the input register holds a live beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= accept;
    end
  end

  // Capture the two timestamps
  always_ff @(posedge clk_i) begin
    if (accept) begin
      fy_q  <= from_year_i;
      fmo_q <= from_month_i;
      fd_q  <= from_day_i;
      fh_q  <= from_hour_i;
      fmi_q <= from_minute_i;
      fs_q  <= from_second_i;
      ty_q  <= till_year_i;
      tmo_q <= till_month_i;
      td_q  <= till_day_i;
      th_q  <= till_hour_i;
      tmi_q <= till_minute_i;
      ts_q  <= till_second_i;
    end
  end

  // Order the pair: the fields concatenate into one lexicographic key
  always_comb begin
    rev  = {fy_q, fmo_q, fd_q, fh_q, fmi_q, fs_q} > {ty_q, tmo_q, td_q, th_q, tmi_q, ts_q};
    a_y  = rev ? ty_q  : fy_q;
    a_mo = rev ? tmo_q : fmo_q;
    a_d  = rev ? td_q  : fd_q;
    a_h  = rev ? th_q  : fh_q;
    a_mi = rev ? tmi_q : fmi_q;
    a_s  = rev ? ts_q  : fs_q;
    b_y  = rev ? fy_q  : ty_q;
    b_mo = rev ? fmo_q : tmo_q;
    b_d  = rev ? fd_q  : td_q;
    b_h  = rev ? fh_q  : th_q;
    b_mi = rev ? fmi_q : tmi_q;
    b_s  = rev ? fs_q  : ts_q;
  end

  // Look up the month before the later date's month; check both years in
  // parallel so the multiply stays off the swap path
  always_comb begin
    b_leap = rev ? is_leap(fy_q) : is_leap(ty_q);
    plen   = prev_month_len(b_mo, b_leap);
  end

  // Subtract field by field, borrowing into the next field up
  always_comb begin
    sec_raw = $signed({4'd0, b_s}) - $signed({4'd0, a_s});
    sec_r   = sec_raw[9] ? sec_raw + SecPerMin : sec_raw;

    min_raw = $signed({4'd0, b_mi}) - $signed({4'd0, a_mi}) - $signed({9'd0, sec_raw[9]});
    min_r   = min_raw[9] ? min_raw + MinPerHour : min_raw;

    hr_raw  = $signed({5'd0, b_h}) - $signed({5'd0, a_h}) - $signed({9'd0, min_raw[9]});
    hr_r    = hr_raw[9] ? hr_raw + HourPerDay : hr_raw;

    day_raw = $signed({5'd0, b_d}) - $signed({5'd0, a_d}) - $signed({9'd0, hr_raw[9]});
    day_r   = day_raw[9] ? day_raw + $signed({5'd0, plen}) : day_raw;

    mon_raw = $signed({6'd0, b_mo}) - $signed({6'd0, a_mo}) - $signed({9'd0, day_raw[9]});
    mon_r   = mon_raw[9] ? mon_raw + MonPerYear : mon_raw;

    yr_r    = $signed({2'd0, b_y}) - $signed({2'd0, a_y}) - $signed({17'd0, mon_raw[9]});
  end

  // Negate a swapped result and wrap each field to its port width
  always_comb begin
    sec_v = rev ? -sec_r : sec_r;
    min_v = rev ? -min_r : min_r;
    hr_v  = rev ? -hr_r  : hr_r;
    day_v = rev ? -day_r : day_r;
    mon_v = rev ? -mon_r : mon_r;
    yr_v  = rev ? -yr_r  : yr_r;

    diff_seconds_d = sec_v[6:0];
    diff_minutes_d = min_v[6:0];
    diff_hours_d   = hr_v[5:0];
    diff_days_d    = day_v[6:0];
    diff_months_d  = mon_v[4:0];
    diff_years_d   = yr_v[16:0];
  end

  // Strobe each result for one cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= valid_q;
    end
  end

  // Load the result register only from a live beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      diff_years_q   <= '0;
      diff_months_q  <= '0;
      diff_days_q    <= '0;
      diff_hours_q   <= '0;
      diff_minutes_q <= '0;
      diff_seconds_q <= '0;
    end else if (valid_q) begin
      diff_years_q   <= diff_years_d;
      diff_months_q  <= diff_months_d;
      diff_days_q    <= diff_days_d;
      diff_hours_q   <= diff_hours_d;
      diff_minutes_q <= diff_minutes_d;
      diff_seconds_q <= diff_seconds_d;
    end
  end

  assign done_o         = done_q;
  assign diff_years_o   = diff_years_q;
  assign diff_months_o  = diff_months_q;
  assign diff_days_o    = diff_days_q;
  assign diff_hours_o   = diff_hours_q;
  assign diff_minutes_o = diff_minutes_q;
  assign diff_seconds_o = diff_seconds_q;

  // Every accepted beat reaches the input stage, then the result strobe
  `CDD_ASSERT_NEXT(a_accept_fills, accept, valid_q, "accepted beat not registered")
  `CDD_ASSERT(a_done_follows, done_o == $past(valid_q), "result strobe out of step")
  `CDD_ASSERT_NEXT(a_result_holds, !valid_q, $stable(diff_years_o) && $stable(diff_days_o),
    "result changed without a beat")

endmodule

`default_nettype wire

>>> bench/tb.sv
`timescale 1ns / 1ps

module tb;

  // Borrow amounts and calendar constants
  localparam int SecPerMin    = 60;
  localparam int MinPerHour   = 60;
  localparam int HourPerDay   = 24;
  localparam int MonPerYear   = 12;
  localparam int LastMonth    = 11;
  localparam int FebIndex     = 1;
  localparam int LongMonthLen = 31;
  localparam int RandomPairs  = 500;
  localparam int CycleLimit   = 200000;
  localparam int DrainCycles  = 8;

  typedef struct {
    logic [15:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
  } stamp_t;

  typedef struct {
    logic signed [16:0] years;
    logic signed [4:0]  months;
    logic signed [6:0]  days;
    logic signed [5:0]  hours;
    logic signed [6:0]  minutes;
    logic signed [6:0]  seconds;
  } span_t;

  typedef struct {
    stamp_t from_ts;
    stamp_t till_ts;
    bit     typed;
    span_t  want;
  } pair_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic start;
  logic busy;
  logic [15:0] from_year;
  logic [3:0]  from_month;
  logic [4:0]  from_day;
  logic [4:0]  from_hour;
  logic [5:0]  from_minute;
  logic [5:0]  from_second;
  logic [15:0] till_year;
  logic [3:0]  till_month;
  logic [4:0]  till_day;
  logic [4:0]  till_hour;
  logic [5:0]  till_minute;
  logic [5:0]  till_second;
  logic        done_o;
  logic signed [16:0] diff_years;
  logic signed [4:0]  diff_months;
  logic signed [6:0]  diff_days;
  logic signed [5:0]  diff_hours;
  logic signed [6:0]  diff_minutes;
  logic signed [6:0]  diff_seconds;

  span_t     pending_spans [$];
  pair_row_t directed_rows [$];
  int        mismatch_count = 0;

  calendar_date_difference_unit u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .from_year_i    (from_year),
    .from_month_i   (from_month),
    .from_day_i     (from_day),
    .from_hour_i    (from_hour),
    .from_minute_i  (from_minute),
    .from_second_i  (from_second),
    .till_year_i    (till_year),
    .till_month_i   (till_month),
    .till_day_i     (till_day),
    .till_hour_i    (till_hour),
    .till_minute_i  (till_minute),
    .till_second_i  (till_second),
    .done_o         (done_o),
    .diff_years_o   (diff_years),
    .diff_months_o  (diff_months),
    .diff_days_o    (diff_days),
    .diff_hours_o   (diff_hours),
    .diff_minutes_o (diff_minutes),
    .diff_seconds_o (diff_seconds)
  );

  // Toggle the clock, 10 ns period
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic stamp_t mk_stamp(int y, int mo, int d, int h, int mi, int s);
    stamp_t st;
    st.year   = 16'(y);
    st.month  = 4'(mo);
    st.day    = 5'(d);
    st.hour   = 5'(h);
    st.minute = 6'(mi);
    st.second = 6'(s);
    return st;
  endfunction

  function automatic span_t mk_span(int y, int mo, int d, int h, int mi, int s);
    span_t sp;
    sp.years   = 17'(y);
    sp.months  = 5'(mo);
    sp.days    = 7'(d);
    sp.hours   = 6'(h);
    sp.minutes = 7'(mi);
    sp.seconds = 7'(s);
    return sp;
  endfunction

  function automatic bit year_is_leap(int year);
    int y;
    y = (year < 0) ? -year : year;
    return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
  endfunction

  // Days in a month; anything outside the calendar counts as a long month
  function automatic int month_length(int year, int month);
    int len;
    if (month < 0 || month > LastMonth) begin
      len = LongMonthLen;
    end else if (month == FebIndex) begin
      len = year_is_leap(year) ? 29 : 28;
    end else if (month == 3 || month == 5 || month == 8 || month == 10) begin
      len = 30;
    end else begin
      len = LongMonthLen;
    end
    return len;
  endfunction

  // Signed calendar difference from the first stamp to the second
  function automatic span_t predict_span(stamp_t f, stamp_t t);
    int  lo [6];
    int  hi [6];
    int  r [6];
    int  i;
    int  tmp;
    int  py;
    int  pm;
    bit  neg;
    bit  decided;
    lo[0] = f.year;  lo[1] = f.month;  lo[2] = f.day;
    lo[3] = f.hour;  lo[4] = f.minute; lo[5] = f.second;
    hi[0] = t.year;  hi[1] = t.month;  hi[2] = t.day;
    hi[3] = t.hour;  hi[4] = t.minute; hi[5] = t.second;
    neg = 1'b0;
    decided = 1'b0;
    // Order the stamps, year first
    for (i = 0; i < 6; i++) begin
      if (!decided && lo[i] != hi[i]) begin
        neg = lo[i] > hi[i];
        decided = 1'b1;
      end
    end
    if (neg) begin
      for (i = 0; i < 6; i++) begin
        tmp = lo[i];
        lo[i] = hi[i];
        hi[i] = tmp;
      end
    end
    for (i = 0; i < 6; i++) r[i] = 0;
    // Subtract field by field, borrowing upward
    r[5] = hi[5] - lo[5];
    if (r[5] < 0) begin r[5] += SecPerMin; r[4] -= 1; end
    r[4] += hi[4] - lo[4];
    if (r[4] < 0) begin r[4] += MinPerHour; r[3] -= 1; end
    r[3] += hi[3] - lo[3];
    if (r[3] < 0) begin r[3] += HourPerDay; r[2] -= 1; end
    r[2] += hi[2] - lo[2];
    if (r[2] < 0) begin
      py = hi[0];
      pm = hi[1] - 1;
      if (pm < 0) begin pm += MonPerYear; py -= 1; end
      r[2] += month_length(py, pm);
      r[1] -= 1;
    end
    r[1] += hi[1] - lo[1];
    if (r[1] < 0) begin r[1] += MonPerYear; r[0] -= 1; end
    r[0] += hi[0] - lo[0];
    if (neg) begin
      for (i = 0; i < 6; i++) r[i] = -r[i];
    end
    return mk_span(r[0], r[1], r[2], r[3], r[4], r[5]);
  endfunction

  function automatic stamp_t rand_stamp(bit raw);
    stamp_t st;
    case ($urandom_range(0, 3))
      0: st.year = 16'($urandom);
      1: st.year = 16'(100 * $urandom_range(0, 655));
      2: st.year = 16'($urandom_range(1890, 2110));
      default: st.year = 16'($urandom_range(0, 8));
    endcase
    st.month  = raw ? 4'($urandom_range(0, 15)) : 4'($urandom_range(0, LastMonth));
    st.day    = raw ? 5'($urandom_range(0, 31)) : 5'($urandom_range(1, 31));
    st.hour   = raw ? 5'($urandom_range(0, 31)) : 5'($urandom_range(0, 23));
    st.minute = raw ? 6'($urandom_range(0, 63)) : 6'($urandom_range(0, 59));
    st.second = raw ? 6'($urandom_range(0, 63)) : 6'($urandom_range(0, 59));
    return st;
  endfunction

  // Build a pair that agrees on a random number of leading fields
  task automatic pick_pair(output stamp_t f, output stamp_t t);
    stamp_t g;
    stamp_t tmp;
    bit     raw;
    int     k;
    raw = ($urandom_range(0, 9) == 0);
    f = rand_stamp(raw);
    g = rand_stamp(raw);
    k = $urandom_range(0, 6);
    t = f;
    if (k <= 0) begin
      t.year = ($urandom_range(0, 1) == 0) ? g.year : f.year + 16'($urandom_range(0, 2));
    end
    if (k <= 1) t.month  = g.month;
    if (k <= 2) t.day    = g.day;
    if (k <= 3) t.hour   = g.hour;
    if (k <= 4) t.minute = g.minute;
    if (k <= 5) t.second = g.second;
    if ($urandom_range(0, 1) == 0) begin
      tmp = f;
      f = t;
      t = tmp;
    end
  endtask

  task automatic report(string msg);
    $display("tb: %s", msg);
    mismatch_count++;
  endtask

  task automatic add_row(stamp_t f, stamp_t t, bit typed, span_t want);
    pair_row_t row;
    row.from_ts = f;
    row.till_ts = t;
    row.typed   = typed;
    row.want    = want;
    directed_rows.push_back(row);
  endtask

  // Present one pair and hold it until the block takes the beat
  task automatic send_pair(stamp_t f, stamp_t t, bit typed, span_t want);
    start       <= 1'b1;
    from_year   <= f.year;
    from_month  <= f.month;
    from_day    <= f.day;
    from_hour   <= f.hour;
    from_minute <= f.minute;
    from_second <= f.second;
    till_year   <= t.year;
    till_month  <= t.month;
    till_day    <= t.day;
    till_hour   <= t.hour;
    till_minute <= t.minute;
    till_second <= t.second;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    pending_spans.push_back(typed ? want : predict_span(f, t));
  endtask

  task automatic hold_off(int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  // Drop start and wait for every pending result
  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending_spans.size() != 0) @(posedge clk_i);
  endtask

  // Check each result beat against the oldest pending span
  always @(posedge clk_i) begin
    span_t seen;
    span_t want;
    if (rst_ni && done_o) begin
      seen = mk_span(diff_years, diff_months, diff_days,
                     diff_hours, diff_minutes, diff_seconds);
      if (pending_spans.size() == 0) begin
        report("result beat with nothing pending");
      end else begin
        want = pending_spans.pop_front();
        if (seen.years != want.years)
          report($sformatf("years got %0d want %0d", seen.years, want.years));
        if (seen.months != want.months)
          report($sformatf("months got %0d want %0d", seen.months, want.months));
        if (seen.days != want.days)
          report($sformatf("days got %0d want %0d", seen.days, want.days));
        if (seen.hours != want.hours)
          report($sformatf("hours got %0d want %0d", seen.hours, want.hours));
        if (seen.minutes != want.minutes)
          report($sformatf("minutes got %0d want %0d", seen.minutes, want.minutes));
        if (seen.seconds != want.seconds)
          report($sformatf("seconds got %0d want %0d", seen.seconds, want.seconds));
      end
    end
  end

  // Abort a hung run
  initial begin
    repeat (CycleLimit) @(posedge clk_i);
    $display("tb: done, errors");
    $finish;
  end

  initial begin
    span_t  no_span;
    stamp_t f;
    stamp_t t;
    int     sent;
    int     burst;
    bit     paused;

    rst_ni      <= 1'b0;
    start       <= 1'b0;
    from_year   <= '0;
    from_month  <= '0;
    from_day    <= '0;
    from_hour   <= '0;
    from_minute <= '0;
    from_second <= '0;
    till_year   <= '0;
    till_month  <= '0;
    till_day    <= '0;
    till_hour   <= '0;
    till_minute <= '0;
    till_second <= '0;
    no_span = mk_span(0, 0, 0, 0, 0, 0);

    // Equal stamps give all zeros
    add_row(mk_stamp(0, 0, 1, 0, 0, 0), mk_stamp(0, 0, 1, 0, 0, 0), 1'b1, no_span);
    add_row(mk_stamp(65535, 15, 31, 31, 63, 63), mk_stamp(65535, 15, 31, 31, 63, 63),
            1'b1, no_span);
    // Widest in-range span, both directions
    add_row(mk_stamp(0, 0, 1, 0, 0, 0), mk_stamp(65535, 11, 31, 23, 59, 59),
            1'b1, mk_span(65535, 11, 30, 23, 59, 59));
    add_row(mk_stamp(65535, 11, 31, 23, 59, 59), mk_stamp(0, 0, 1, 0, 0, 0),
            1'b1, mk_span(-65535, -11, -30, -23, -59, -59));
    // One-second steps
    add_row(mk_stamp(2024, 5, 10, 12, 30, 59), mk_stamp(2024, 5, 10, 12, 31, 0),
            1'b1, mk_span(0, 0, 0, 0, 0, 1));
    add_row(mk_stamp(2024, 5, 10, 12, 31, 0), mk_stamp(2024, 5, 10, 12, 30, 59),
            1'b1, mk_span(0, 0, 0, 0, 0, -1));
    // Borrow through every field across a year end
    add_row(mk_stamp(2023, 11, 31, 23, 59, 59), mk_stamp(2024, 0, 1, 0, 0, 0),
            1'b0, no_span);
    // Borrow from January, including the step back into year zero
    add_row(mk_stamp(1999, 11, 31, 0, 0, 0), mk_stamp(2000, 0, 1, 0, 0, 0), 1'b0, no_span);
    add_row(mk_stamp(0, 11, 31, 5, 0, 0), mk_stamp(1, 0, 1, 4, 0, 0), 1'b0, no_span);
    // February lengths: leap, century, four-century, year zero
    add_row(mk_stamp(2024, 1, 28, 0, 0, 0), mk_stamp(2024, 2, 1, 0, 0, 0), 1'b0, no_span);
    add_row(mk_stamp(1900, 1, 28, 0, 0, 0), mk_stamp(1900, 2, 1, 0, 0, 0), 1'b0, no_span);
    add_row(mk_stamp(2000, 1, 28, 0, 0, 0), mk_stamp(2000, 2, 1, 0, 0, 0), 1'b0, no_span);
    add_row(mk_stamp(0, 1, 20, 0, 0, 0), mk_stamp(0, 2, 3, 0, 0, 0), 1'b0, no_span);
    // Day field left negative after the borrow
    add_row(mk_stamp(2001, 0, 31, 0, 0, 0), mk_stamp(2001, 2, 1, 0, 0, 0), 1'b0, no_span);
    add_row(mk_stamp(2001, 2, 1, 0, 0, 0), mk_stamp(2001, 0, 31, 0, 0, 0), 1'b0, no_span);
    // Months past December look back to a long month
    add_row(mk_stamp(100, 12, 31, 0, 0, 0), mk_stamp(100, 13, 1, 0, 0, 0), 1'b0, no_span);
    add_row(mk_stamp(100, 14, 30, 0, 0, 0), mk_stamp(100, 15, 1, 0, 0, 0), 1'b0, no_span);
    // Raw out-of-range clock fields and day zero
    add_row(mk_stamp(7, 3, 0, 31, 63, 63), mk_stamp(7, 3, 31, 0, 0, 0), 1'b0, no_span);
    add_row(mk_stamp(65535, 15, 31, 31, 63, 63), mk_stamp(0, 0, 0, 0, 0, 0), 1'b0, no_span);

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Walk the directed table with a few short gaps
    foreach (directed_rows[i]) begin
      send_pair(directed_rows[i].from_ts, directed_rows[i].till_ts,
                directed_rows[i].typed, directed_rows[i].want);
      if ($urandom_range(0, 3) == 0) hold_off($urandom_range(1, 3));
    end
    drain_results();

    // Random pairs in bursts, with one full drain midway
    sent = 0;
    paused = 1'b0;
    while (sent < RandomPairs) begin
      burst = $urandom_range(1, 24);
      repeat (burst) begin
        pick_pair(f, t);
        send_pair(f, t, 1'b0, no_span);
        sent++;
      end
      if (!paused && sent >= RandomPairs / 2) begin
        drain_results();
        paused = 1'b1;
      end else if ($urandom_range(0, 3) != 0) begin
        hold_off($urandom_range(1, 6));
      end
    end

    drain_results();
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
